// ===== rtl/wbps_pkg.sv =====
`default_nettype none

package wbps_pkg;

   localparam int unsigned PATTERN_SLOTS   = 32;
   localparam int unsigned PATTERN_WORDS   = 4;
   localparam int unsigned MAX_PATTERN_DEF = 32;
   localparam int unsigned OFFSET_BITS_DEF = 32;
   localparam int unsigned CSR_INDEX_BITS  = 3;
   localparam int unsigned LENGTH_BITS     = 6;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CARE_MASK      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_BASE     = 3'd6;

   typedef logic [PATTERN_SLOTS-1:0][7:0] pattern_type;

   typedef struct packed {
      pattern_type                pattern;
      logic [PATTERN_SLOTS-1:0]   care_mask;
      logic [LENGTH_BITS-1:0]     pattern_length;
      logic [63:0]                image_base;
   } cfg_type;

   typedef struct packed {
      logic        emit;
      logic        found;
      logic [63:0] match_address;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/wbps_csr.sv =====
`default_nettype none

module wbps_csr
   import wbps_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [63:0]               csr_data,
   output cfg_type                        cfg
);

   logic [63:0]              word0_ff, word1_ff, word2_ff, word3_ff;
   logic [PATTERN_SLOTS-1:0] care_ff;
   logic [LENGTH_BITS-1:0]   length_ff;
   logic [63:0]              base_ff;
   logic                     wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         word0_ff  <= '0;
         word1_ff  <= '0;
         word2_ff  <= '0;
         word3_ff  <= '0;
         care_ff   <= '1;
         length_ff <= LENGTH_BITS'(1);
         base_ff   <= '0;
      end else if (wr) begin
         case (csr_index)
            CSR_PATTERN_WORD_0: word0_ff  <= csr_data;
            CSR_PATTERN_WORD_1: word1_ff  <= csr_data;
            CSR_PATTERN_WORD_2: word2_ff  <= csr_data;
            CSR_PATTERN_WORD_3: word3_ff  <= csr_data;
            CSR_CARE_MASK:      care_ff   <= csr_data[PATTERN_SLOTS-1:0];
            CSR_PATTERN_LENGTH: length_ff <= csr_data[LENGTH_BITS-1:0];
            CSR_IMAGE_BASE:     base_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // byte 0 of the pattern sits in the low bits of word 0
   assign cfg.pattern        = pattern_type'({word3_ff, word2_ff, word1_ff, word0_ff});
   assign cfg.care_mask      = care_ff;
   assign cfg.pattern_length = length_ff;
   assign cfg.image_base     = base_ff;

endmodule

`default_nettype wire

// ===== rtl/wbps_match.sv =====
`default_nettype none

module wbps_match
   import wbps_pkg::*;
#(
   parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
   parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   input  wire cfg_type    cfg,
   output result_type      result
);

   localparam logic [LENGTH_BITS-1:0] MAX_LEN = LENGTH_BITS'(MAX_PATTERN);
   localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;

   // entry 0 holds the newest byte
   logic [7:0]             win_ff [MAX_PATTERN];
   logic [7:0]             win_in [MAX_PATTERN];
   logic [OFFSET_BITS-1:0] seen_ff, seen_in, seen_next;
   logic                   reported_ff, reported_in;
   logic [LENGTH_BITS-1:0] len_eff;
   logic [MAX_PATTERN-1:0] pos_ok;
   logic                   hit;
   logic [OFFSET_BITS-1:0] start_offset;

   always_comb begin
      if (cfg.pattern_length == '0) begin
         len_eff = LENGTH_BITS'(1);
      end else if (cfg.pattern_length > MAX_LEN) begin
         len_eff = MAX_LEN;
      end else begin
         len_eff = cfg.pattern_length;
      end
   end

   always_comb begin
      win_in[0] = data_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         win_in[k] = win_ff[k-1];
      end
   end

   assign seen_next = (seen_ff == CNT_MAX) ? seen_ff : seen_ff + OFFSET_BITS'(1);

   // window entry k lines up with pattern byte len-1-k
   always_comb begin
      logic [LENGTH_BITS-1:0] j_idx;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         j_idx = len_eff - LENGTH_BITS'(1) - LENGTH_BITS'(k);
         if (LENGTH_BITS'(k) >= len_eff || !cfg.care_mask[j_idx[4:0]]) begin
            pos_ok[k] = 1'b1;
         end else begin
            pos_ok[k] = (win_in[k] == cfg.pattern[j_idx[4:0]]);
         end
      end
   end

   assign hit = !reported_ff && (seen_next >= OFFSET_BITS'(len_eff)) && (&pos_ok);
   assign start_offset = seen_next - OFFSET_BITS'(len_eff);

   assign result.emit          = step && (hit || (last_byte && !reported_ff));
   assign result.found         = hit;
   assign result.match_address = hit ? cfg.image_base + 64'(start_offset) : 64'd0;

   assign seen_in     = last_byte ? '0 : seen_next;
   assign reported_in = last_byte ? 1'b0 : (reported_ff | hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (step) begin
         seen_ff     <= seen_in;
         reported_ff <= reported_in;
      end
   end

   // window contents older than the count are never compared
   always_ff @(posedge clock) begin
      if (step) begin
         win_ff <= win_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_hit_sets_reported: assert property (@(posedge clock) disable iff (reset)
      step && hit && !last_byte |=> reported_ff)
      else $error("match did not mark the image as reported");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step && last_byte |=> seen_ff == '0 && !reported_ff)
      else $error("scan state not cleared after last byte");

   a_no_second_hit: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> !hit)
      else $error("second match in one image");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      result.emit && !result.found |-> result.match_address == 64'd0)
      else $error("not-found result with nonzero address");
`endif

endmodule

`default_nettype wire

// ===== rtl/wildcard_byte_pattern_scanner.sv =====
// An accepted request is held in the input register; any result it emits is then held
// in the result register. Throughput: one request per cycle unless the result stalls;
// the window compare sits between them, so a stalled result only holds the input stage.
// Reset: synchronous, active high; clears the scan count, match flag and valid bits,
// and returns the registers to their defaults (care mask all ones, length 1).
`default_nettype none

module wildcard_byte_pattern_scanner
   import wbps_pkg::*;
#(
   parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
   parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_data_byte,
   input  wire logic                      req_last_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_found,
   output logic [63:0]                    rsp_match_address,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [63:0]               csr_data
);

   cfg_type     cfg;
   result_type  result;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;
   logic        advance;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_found_ff;
   logic [63:0] rsp_addr_ff;

   wbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   wbps_match #(
      .MAX_PATTERN (MAX_PATTERN),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (s1_byte_ff),
      .last_byte (s1_last_ff),
      .cfg       (cfg),
      .result    (result)
   );

   // input stage moves on whenever the result slot is free or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   always_comb begin
      if (advance) begin
         rsp_valid_in = result.emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
      if (advance && result.emit) begin
         rsp_found_ff <= result.found;
         rsp_addr_ff  <= result.match_address;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_match_address = rsp_addr_ff;

`ifndef NO_ASSERTIONS
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_last_ff))
      else $error("input stage lost a request while stalled");

   a_advance_slot_free: assert property (@(posedge clock) disable iff (reset)
      advance |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwritten before it was taken");

   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared without a processed request");
`endif

endmodule

`default_nettype wire
